FILE: src/pngse_pkg.sv
// ============================================================================
// pngse_pkg: shared types and constants of the PNG stored-deflate encoder
// Command word passed from the front end to the byte sequencer, PNG/zlib
// constants, and the byte-wise CRC-32 and big-endian byte select helpers.
// ============================================================================
package pngse_pkg;

    // Field and port widths
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int MAX_SIDE   = 8192;
    localparam int SIDE_W     = CFG_DATA_W;
    localparam int COL_W      = $clog2(MAX_SIDE);
    localparam int RAW_W      = 29;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // Checksums
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
    localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // PNG / zlib stream constants
    localparam logic [7:0]  PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                             8'd13, 8'd10, 8'd26, 8'd10};
    localparam logic [31:0] IHDR_LEN    = 32'd13;
    localparam logic [31:0] IEND_LEN    = 32'd0;
    localparam logic [31:0] TYPE_IHDR   = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT   = 32'h49444154;
    localparam logic [31:0] TYPE_IEND   = 32'h49454E44;
    localparam logic [7:0]  IHDR_DEPTH  = 8'd8;
    localparam logic [7:0]  IHDR_COLOR  = 8'd6;
    localparam logic [7:0]  ZLIB_CMF    = 8'h78;
    localparam logic [7:0]  ZLIB_FLG    = 8'h01;
    localparam logic [7:0]  FILTER_NONE = 8'd0;
    // zlib header (2) plus Adler trailer (4)
    localparam logic [31:0] ZLIB_OVERHEAD = 32'd6;

    // One queued command: what the sequencer must emit for one pixel word
    typedef struct packed {
        logic              trl_only;  // emit the deferred trailer, drop pixel
        logic              hdr;       // file header precedes the pixel
        logic              filt;      // row start: filter byte first
        logic              last;      // last pixel: trailer follows
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic [PIX_W-1:0]  pixel;
    } t_cmd;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Byte k of a word, most significant first
    function automatic logic [7:0] be_byte(input logic [31:0] word,
                                           input logic [1:0]  k);
        logic [4:0] sh;
        sh = {~k, 3'b000};
        return 8'(word >> sh);
    endfunction

endpackage

FILE: src/pngse_if.sv
// ============================================================================
// pngse_if: stream channels of the PNG encoder
// Pixel word channel and PNG byte channel, valid/ready handshake.
// ============================================================================
interface pngse_pix_if;
    import pngse_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_rgba;

    modport source (output valid, output pixel_rgba, input ready);
    modport sink   (input valid, input pixel_rgba, output ready);
endinterface

interface pngse_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       file_done;

    modport source (output valid, output out_byte, output last_of_run,
                    output file_done, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input file_done, output ready);
endinterface

FILE: src/png_stored_deflate_encoder.sv
// ============================================================================
// png_stored_deflate_encoder: streaming PNG writer, RGBA8, stored deflate
// Takes RGBA pixel words in raster order and emits a complete PNG file.
// ============================================================================
// A pixel word passes the queue, the sequencer state and the output byte register
//   before its first byte shows on o_png. Throughput: one byte per cycle while the
//   sink is ready, set by that register; a pixel is 4 bytes, +1 per row start, +5
//   per block header, +43 for the file header first and +20 for the trailer last.
// Reset: synchronous, active low; empties the queue, idles the sequencer and
//   sets both size registers to 1.
module png_stored_deflate_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pngse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pngse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pngse_pix_if.sink                        i_pix,
    pngse_byte_if.source                     o_png
);
    import pngse_pkg::*;

    // front end -> queue
    logic fr_valid, fr_ready;
    t_cmd fr_cmd;
    // queue -> sequencer
    logic q_valid, q_ready;
    t_cmd q_cmd;

    // Front end: holds width/height registers, latches them on the first
    // pixel of a file, and counts columns and rows so that each word is
    // tagged with header, filter-byte and end-of-image flags. A one-pixel
    // image defers its trailer to a command of its own for the next word.
    pngse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (i_pix.valid),
        .o_pix_ready (i_pix.ready),
        .i_pixel     (i_pix.pixel_rgba),
        .o_cmd_valid (fr_valid),
        .i_cmd_ready (fr_ready),
        .o_cmd       (fr_cmd)
    );

    // Queue: lets the front end take pixels while the sequencer is still
    // busy with a long header or trailer burst.
    pngse_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_data  (fr_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_cmd)
    );

    // Sequencer: walks header, block headers, raw bytes and trailer one byte
    // per cycle into a single output register; the register loads whenever
    // it is empty or being drained, so a stalled sink holds the byte and
    // freezes the sequencer with it. CRC-32 and Adler-32 advance as bytes
    // load. The IDAT length is worked out in a short multiply pipeline
    // while the signature bytes go out.
    pngse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (o_png.valid),
        .i_ready     (o_png.ready),
        .o_byte      (o_png.out_byte),
        .o_last      (o_png.last_of_run),
        .o_done      (o_png.file_done)
    );

endmodule

FILE: src/pngse_front.sv
// ============================================================================
// pngse_front: pixel intake and classification
// Holds the size registers, tracks row and column, and turns each pixel word
// into a command for the byte sequencer.
// ============================================================================
module pngse_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pngse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pngse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_pix_valid,
    output logic                             o_pix_ready,
    input  logic [pngse_pkg::PIX_W-1:0]      i_pixel,
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_ready,
    output pngse_pkg::t_cmd                  o_cmd
);
    import pngse_pkg::*;

    logic [SIDE_W-1:0] r_cfg_w, r_cfg_h;
    logic [SIDE_W-1:0] r_w, r_h, n_w, n_h;
    logic [COL_W-1:0]  r_col, r_row, n_col, n_row;
    logic              r_in_img, n_in_img;
    logic              r_trl_pend, n_trl_pend;

    logic [SIDE_W-1:0] w_eff, h_eff;
    logic              col_last, row_last, img_last, push;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        if (v == '0) begin
            return SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            return SIDE_W'(MAX_SIDE);
        end else begin
            return v;
        end
    endfunction

    // latch size only at the first pixel of a file
    assign w_eff    = r_in_img ? r_w : clamp_side(r_cfg_w);
    assign h_eff    = r_in_img ? r_h : clamp_side(r_cfg_h);
    assign col_last = SIDE_W'(r_col) == (w_eff - SIDE_W'(1));
    assign row_last = SIDE_W'(r_row) == (h_eff - SIDE_W'(1));
    assign img_last = col_last && row_last;

    assign o_pix_ready = i_cmd_ready;
    assign o_cmd_valid = i_pix_valid;
    assign push        = i_pix_valid && i_cmd_ready;

    always_comb begin
        o_cmd.trl_only = r_trl_pend;
        o_cmd.hdr      = !r_trl_pend && !r_in_img;
        o_cmd.filt     = r_col == '0;
        // single-pixel image: trailer goes out with the next word
        o_cmd.last     = img_last && r_in_img;
        o_cmd.w        = w_eff;
        o_cmd.h        = h_eff;
        o_cmd.pixel    = i_pixel;
    end

    always_comb begin
        n_w        = r_w;
        n_h        = r_h;
        n_col      = r_col;
        n_row      = r_row;
        n_in_img   = r_in_img;
        n_trl_pend = r_trl_pend;
        if (push) begin
            if (r_trl_pend) begin
                n_trl_pend = 1'b0;
                n_in_img   = 1'b0;
            end else begin
                if (!r_in_img) begin
                    n_w      = w_eff;
                    n_h      = h_eff;
                    n_in_img = 1'b1;
                end
                if (img_last) begin
                    n_col = '0;
                    n_row = '0;
                    if (r_in_img) begin
                        n_in_img = 1'b0;
                    end else begin
                        n_trl_pend = 1'b1;
                    end
                end else if (col_last) begin
                    n_col = '0;
                    n_row = r_row + COL_W'(1);
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= SIDE_W'(1);
            r_cfg_h    <= SIDE_W'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_in_img   <= 1'b0;
            r_trl_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                endcase
            end
            r_col      <= n_col;
            r_row      <= n_row;
            r_in_img   <= n_in_img;
            r_trl_pend <= n_trl_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_h <= n_h;
    end

endmodule

FILE: src/pngse_queue.sv
// ============================================================================
// pngse_queue: command queue
// Short FIFO between the front end and the byte sequencer.
// ============================================================================
module pngse_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  pngse_pkg::t_cmd i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output pngse_pkg::t_cmd o_pop_data
);
    import pngse_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;

    assign o_push_ready = r_cnt != CNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ptr_inc(r_wp);
            if (pop)  r_rp <= ptr_inc(r_rp);
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_push_data;
    end

endmodule

FILE: src/pngse_back.sv
// ============================================================================
// pngse_back: byte sequencer
// Emits file header, stored block headers, raw bytes and trailer one byte a
// cycle unless the sink stalls, keeping chunk CRC-32 and raw data Adler-32.
// ============================================================================
module pngse_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  pngse_pkg::t_cmd i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last,
    output logic            o_done
);
    import pngse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HDR  = 4'b0010,
        S_RAW  = 4'b0100,
        S_TRL  = 4'b1000
    } t_bstate;

    localparam int IDX_W = 6;
    localparam int BLK_W = SIDE_W;
    localparam logic [IDX_W-1:0] HDR_IHDR_TYPE = 6'd12;
    localparam logic [IDX_W-1:0] HDR_IDAT_TYPE = 6'd37;
    localparam logic [IDX_W-1:0] HDR_LAST      = 6'd42;
    localparam logic [IDX_W-1:0] TRL_LAST      = 6'd19;
    localparam logic [2:0]       BH_LAST       = 3'd4;
    localparam logic [2:0]       RAW_LAST      = 3'd4;

    t_bstate          r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [2:0]       r_bh, n_bh, r_rix, n_rix;
    t_cmd             r_cmd, n_cmd;
    logic [31:0]      r_crc, n_crc;
    logic [15:0]      r_alo, n_alo, r_ahi, n_ahi;
    logic [15:0]      r_blk, n_blk;
    logic [RAW_W-1:0] r_raw, n_raw;
    logic [RAW_W-1:0] r_prod;
    logic [BLK_W-1:0] r_nblk;
    logic [31:0]      r_ilen;
    logic             r_ovalid, r_olast, r_odone;
    logic [7:0]       r_obyte;

    logic        adv, start;
    logic [7:0]  e_byte;
    logic        e_crc, e_init, e_fin, e_done, e_adler;
    logic [15:0] bh_len;
    logic        bh_final;
    logic [7:0]  raw_byte;
    logic [16:0] alo_sum, ahi_sum;
    logic [15:0] alo_new, ahi_new;
    logic [31:0] crc_base;
    logic [29:0] blk_y;
    logic [16:0] blk_s;

    // ---- stored block header fields
    assign bh_final = r_raw[RAW_W-1:16] == '0;
    assign bh_len   = bh_final ? r_raw[15:0] : BLOCK_MAX;
    assign raw_byte = (r_rix == '0) ? FILTER_NONE
                                    : be_byte(r_cmd.pixel, 2'(r_rix - 3'd1));

    // ---- byte select
    always_comb begin
        e_byte  = '0;
        e_crc   = 1'b0;
        e_init  = 1'b0;
        e_fin   = 1'b0;
        e_done  = 1'b0;
        e_adler = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                e_byte = '0;
            end
            S_HDR: begin
                e_crc  = 1'b1;
                e_init = (r_idx == HDR_IHDR_TYPE) || (r_idx == HDR_IDAT_TYPE);
                unique case (r_idx) inside
                    [6'd0:6'd7]: begin
                        e_byte = PNG_SIG[r_idx[2:0]];
                        e_crc  = 1'b0;
                    end
                    [6'd8:6'd11]: begin
                        e_byte = be_byte(IHDR_LEN, r_idx[1:0]);
                        e_crc  = 1'b0;
                    end
                    [6'd12:6'd15]: e_byte = be_byte(TYPE_IHDR, r_idx[1:0]);
                    [6'd16:6'd19]: e_byte = be_byte(32'(r_cmd.w), r_idx[1:0]);
                    [6'd20:6'd23]: e_byte = be_byte(32'(r_cmd.h), r_idx[1:0]);
                    6'd24:         e_byte = IHDR_DEPTH;
                    6'd25:         e_byte = IHDR_COLOR;
                    [6'd26:6'd28]: e_byte = '0;
                    [6'd29:6'd32]: begin
                        e_byte = be_byte(~r_crc, 2'(r_idx - 6'd29));
                        e_crc  = 1'b0;
                    end
                    [6'd33:6'd36]: begin
                        e_byte = be_byte(r_ilen, 2'(r_idx - 6'd33));
                        e_crc  = 1'b0;
                    end
                    [6'd37:6'd40]: e_byte = be_byte(TYPE_IDAT, 2'(r_idx - 6'd37));
                    6'd41:         e_byte = ZLIB_CMF;
                    6'd42:         e_byte = ZLIB_FLG;
                    default:       e_byte = '0;
                endcase
            end
            S_RAW: begin
                e_crc = 1'b1;
                if (r_blk == '0) begin
                    unique case (r_bh)
                        3'd0:    e_byte = {7'd0, bh_final};
                        3'd1:    e_byte = bh_len[7:0];
                        3'd2:    e_byte = bh_len[15:8];
                        3'd3:    e_byte = ~bh_len[7:0];
                        3'd4:    e_byte = ~bh_len[15:8];
                        default: e_byte = '0;
                    endcase
                end else begin
                    e_byte  = raw_byte;
                    e_adler = 1'b1;
                    e_fin   = (r_rix == RAW_LAST) && !r_cmd.last;
                end
            end
            S_TRL: begin
                unique case (r_idx[4:2])
                    3'd0: begin
                        e_byte = be_byte({r_ahi, r_alo}, r_idx[1:0]);
                        e_crc  = 1'b1;
                    end
                    3'd1:    e_byte = be_byte(~r_crc, r_idx[1:0]);
                    3'd2:    e_byte = be_byte(IEND_LEN, r_idx[1:0]);
                    3'd3: begin
                        e_byte = be_byte(TYPE_IEND, r_idx[1:0]);
                        e_crc  = 1'b1;
                        e_init = r_idx[1:0] == 2'd0;
                    end
                    3'd4:    e_byte = be_byte(~r_crc, r_idx[1:0]);
                    default: e_byte = '0;
                endcase
                e_fin  = r_idx == TRL_LAST;
                e_done = r_idx == TRL_LAST;
            end
            default: e_byte = '0;
        endcase
    end

    // ---- Adler-32 step, both sums reduced by one compare and subtract
    assign alo_sum = {1'b0, r_alo} + {9'd0, e_byte};
    assign alo_new = (alo_sum >= ADLER_MOD) ? 16'(alo_sum - ADLER_MOD) : alo_sum[15:0];
    assign ahi_sum = {1'b0, r_ahi} + {1'b0, alo_new};
    assign ahi_new = (ahi_sum >= ADLER_MOD) ? 16'(ahi_sum - ADLER_MOD) : ahi_sum[15:0];
    assign crc_base = e_init ? ALL_ONES : r_crc;

    // ---- handshake
    assign adv         = !r_ovalid || i_ready;
    assign o_cmd_ready = (r_state == S_IDLE) || (adv && e_fin);
    assign start       = i_cmd_valid && o_cmd_ready;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_bh    = r_bh;
        n_rix   = r_rix;
        n_cmd   = r_cmd;
        n_crc   = r_crc;
        n_alo   = r_alo;
        n_ahi   = r_ahi;
        n_blk   = r_blk;
        n_raw   = r_raw;
        if (adv && (r_state != S_IDLE)) begin
            if (e_crc) n_crc = crc32_byte(crc_base, e_byte);
            if (e_adler) begin
                n_alo = alo_new;
                n_ahi = ahi_new;
                n_blk = r_blk - 16'd1;
                n_raw = r_raw - RAW_W'(1);
            end
            unique case (r_state)
                S_HDR: begin
                    if (r_idx == HDR_LAST) begin
                        n_state = S_RAW;
                        n_rix   = r_cmd.filt ? 3'd0 : 3'd1;
                        n_bh    = '0;
                        n_raw   = r_prod;
                        n_blk   = '0;
                        n_alo   = 16'd1;
                        n_ahi   = '0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                S_RAW: begin
                    if (r_blk == '0) begin
                        if (r_bh == BH_LAST) begin
                            n_bh  = '0;
                            n_blk = bh_len;
                        end else begin
                            n_bh = r_bh + 3'd1;
                        end
                    end else if (r_rix == RAW_LAST) begin
                        n_state = r_cmd.last ? S_TRL : S_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_rix = r_rix + 3'd1;
                    end
                end
                S_TRL: begin
                    if (r_idx == TRL_LAST) begin
                        n_state = S_IDLE;
                        n_crc   = ALL_ONES;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                default: n_state = r_state;
            endcase
        end
        // take the next command on the cycle the current one finishes
        if (start) begin
            n_cmd = i_cmd;
            n_idx = '0;
            n_bh  = '0;
            n_rix = i_cmd.filt ? 3'd0 : 3'd1;
            priority if (i_cmd.trl_only) begin
                n_state = S_TRL;
            end else if (i_cmd.hdr) begin
                n_state = S_HDR;
            end else begin
                n_state = S_RAW;
            end
        end
    end

    // ---- IDAT length: raw = h*(4w+1), blocks = ceil(raw/65535)
    assign blk_y = {1'b0, r_prod} + 30'(BLOCK_MAX - 16'd1);
    assign blk_s = 17'(blk_y[29:16]) + 17'(blk_y[15:0]);

    always_ff @(posedge i_clk) begin
        r_prod <= RAW_W'(30'(r_cmd.h) * 30'({r_cmd.w, 2'b01}));
        r_nblk <= blk_y[29:16] + BLK_W'(blk_s >= 17'(BLOCK_MAX));
        r_ilen <= 32'(r_prod) + 32'({r_nblk, 2'b00}) + 32'(r_nblk) + ZLIB_OVERHEAD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_bh     <= '0;
            r_rix    <= '0;
            r_crc    <= ALL_ONES;
            r_alo    <= 16'd1;
            r_ahi    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bh    <= n_bh;
            r_rix   <= n_rix;
            r_crc   <= n_crc;
            r_alo   <= n_alo;
            r_ahi   <= n_ahi;
            if (adv) r_ovalid <= r_state != S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_blk <= n_blk;
        r_raw <= n_raw;
        if (adv) begin
            r_obyte <= e_byte;
            r_olast <= e_fin;
            r_odone <= e_done;
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;
    assign o_done  = r_odone;

endmodule

FILE: src/pngse_chk.sv
// ============================================================================
// pngse_chk: port-level checks of the PNG encoder
// Watches the pixel and byte channels and is bound to the top level.
// ============================================================================
module pngse_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_out_done
);
    import pngse_pkg::*;

    logic [2:0] r_pend, n_pend;
    logic       r_at_start;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;
    assign n_pend  = r_pend + 3'(in_acc) - 3'(out_acc && i_out_last);

    // words taken whose last byte has not gone out yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= '0;
            r_at_start <= 1'b1;
        end else begin
            r_pend <= n_pend;
            if (out_acc) r_at_start <= i_out_done;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 3'd0)
        else $error("output byte with no pixel word outstanding");

    a_sig_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_at_start |-> i_out_byte == PNG_SIG[0])
        else $error("file does not open with the PNG signature");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_last)
        else $error("file end not on the last byte of a run");

endmodule

bind png_stored_deflate_encoder pngse_chk u_pngse_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_png.valid),
    .i_out_ready (o_png.ready),
    .i_out_byte  (o_png.out_byte),
    .i_out_last  (o_png.last_of_run),
    .i_out_done  (o_png.file_done)
);
